/* hw/rtl/hpq_pkg.sv */
// Package: types and constants shared by the priority queue modules.
package hpq_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned PrioWidth = 8;
  localparam int unsigned SeqWidth  = 64;
  localparam int unsigned IdxWidth  = $clog2(Capacity);
  localparam int unsigned CntWidth  = $clog2(Capacity + 1);
  localparam int unsigned EntWidth  = DataWidth + PrioWidth + SeqWidth;

  localparam logic       KindInsert  = 1'b0;
  localparam logic       KindExtract = 1'b1;
  localparam logic [1:0] StatDone    = 2'd0;
  localparam logic [1:0] StatFull    = 2'd1;
  localparam logic [1:0] StatEmpty   = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic [DataWidth-1:0] data_in;
    logic [PrioWidth-1:0] priority_in;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [DataWidth-1:0] data_out;
    logic [PrioWidth-1:0] priority_out;
    logic [CntWidth-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic [DataWidth-1:0] data;
    logic [PrioWidth-1:0] prio;
    logic [SeqWidth-1:0]  seq;
  } entry_t;

  // true when entry a is served before entry b
  function automatic logic serves_before(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) r = a.prio > b.prio;
    else                  r = a.seq < b.seq;
    return r;
  endfunction

endpackage

/* hw/rtl/hpq_ram.sv */
// Generic single-port-write, dual-read-port RAM with registered read data.
module hpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* hw/rtl/hpq_ctrl.sv */
// Heap sequencer: sift up on insert, sift down on extract, over the slot RAM.
module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  req_t                req_i,
  input  logic                auto_discard_i,
  output logic                busy_o,
  output logic                done_o,
  output rsp_t                rsp_o,
  output logic                we_o,
  output logic [IdxWidth-1:0] waddr_o,
  output entry_t              wdata_o,
  output logic [IdxWidth-1:0] raddr_a_o,
  output logic [IdxWidth-1:0] raddr_b_o,
  input  entry_t              rdata_a_i,
  input  entry_t              rdata_b_i
);

  typedef enum logic [2:0] {
    StIdle, StUpRd, StUpCmp, StExRd, StExRoot, StDnRd, StDnCmp
  } state_e;

  state_e              state_q;
  logic [CntWidth-1:0] fill_q;
  logic [SeqWidth-1:0] seq_q;
  logic [IdxWidth-1:0] pos_q;
  entry_t              cur_q;
  logic                busy_q, done_q;
  rsp_t                rsp_q;

  logic                we;
  logic [IdxWidth-1:0] waddr, ra, rb;
  entry_t              wdata;
  logic                up_more, done_d;

  // sift-down helpers: child indices, widened to test against fill count
  logic [CntWidth:0] lc, rc;
  logic              l_ok, r_ok, l_win, r_win;
  entry_t            best;
  assign lc    = {1'b0, pos_q, 1'b1};
  assign rc    = lc + 1'b1;
  assign l_ok  = lc < {1'b0, fill_q};
  assign r_ok  = rc < {1'b0, fill_q};
  always_comb begin
    l_win = l_ok && serves_before(rdata_a_i, cur_q);
    best  = l_win ? rdata_a_i : cur_q;
    r_win = r_ok && serves_before(rdata_b_i, best);
  end

  logic [IdxWidth-1:0] parent;
  assign parent = (pos_q - 1'b1) >> 1;

  // the root has no parent to climb past
  assign up_more = (pos_q != '0) && serves_before(cur_q, rdata_a_i);

  always_comb begin
    we = 1'b0; waddr = pos_q; wdata = cur_q; ra = parent; rb = parent;
    done_d = 1'b0;
    unique case (state_q)
      StIdle:  begin
        done_d = start_i && ((req_i.kind == KindInsert) ?
                 (fill_q == CntWidth'(Capacity) && !auto_discard_i) : (fill_q == '0));
      end
      StUpRd:  ra = parent;
      StUpCmp: begin
        we = 1'b1;
        if (up_more) wdata = rdata_a_i;
        done_d = !up_more;
      end
      StExRd:  begin ra = '0; rb = fill_q[IdxWidth-1:0]; end
      StExRoot: done_d = (fill_q == '0);
      StDnRd:  begin ra = lc[IdxWidth-1:0]; rb = rc[IdxWidth-1:0]; end
      StDnCmp: begin
        we = 1'b1;
        if (r_win)      wdata = rdata_b_i;
        else if (l_win) wdata = rdata_a_i;
        done_d = !r_win && !l_win;
      end
      default: ;
    endcase
  end

  assign we_o = we; assign waddr_o = waddr; assign wdata_o = wdata;
  assign raddr_a_o = ra; assign raddr_b_o = rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; fill_q <= '0; seq_q <= '0; busy_q <= 1'b0;
      done_q <= 1'b0; rsp_q <= '0; pos_q <= '0; cur_q <= '0;
    end else begin
      done_q <= done_d;
      unique case (state_q)
        StIdle: if (start_i) begin
          if (req_i.kind == KindInsert) begin
            if (fill_q == CntWidth'(Capacity) && !auto_discard_i) begin
              rsp_q <= '{status: StatFull, data_out: '0, priority_out: '0, count: fill_q};
            end else begin
              rsp_q <= '0;
              pos_q <= (fill_q == CntWidth'(Capacity)) ?
                       IdxWidth'(Capacity - 1) : fill_q[IdxWidth-1:0];
              if (fill_q != CntWidth'(Capacity)) fill_q <= fill_q + 1'b1;
              cur_q <= '{data: req_i.data_in, prio: req_i.priority_in, seq: seq_q};
              seq_q <= seq_q + 1'b1;
              busy_q <= 1'b1; state_q <= StUpRd;
            end
          end else if (fill_q == '0) begin
            rsp_q <= '{status: StatEmpty, data_out: '0, priority_out: '0, count: '0};
          end else begin
            rsp_q <= '0;
            fill_q <= fill_q - 1'b1; busy_q <= 1'b1; state_q <= StExRd;
          end
        end
        StUpRd: begin
          if (pos_q == '0) begin
            state_q <= StUpCmp;
          end else state_q <= StUpCmp;
        end
        StUpCmp: begin
          if (up_more) begin
            pos_q <= parent; state_q <= StUpRd;
          end else begin
            rsp_q.count <= fill_q; busy_q <= 1'b0; state_q <= StIdle;
          end
        end
        StExRd: state_q <= StExRoot;
        StExRoot: begin
          rsp_q <= '{status: StatDone, data_out: rdata_a_i.data,
                     priority_out: rdata_a_i.prio, count: fill_q};
          cur_q <= rdata_b_i; pos_q <= '0;
          if (fill_q == '0) begin
            busy_q <= 1'b0; state_q <= StIdle;
          end else state_q <= StDnRd;
        end
        StDnRd: state_q <= StDnCmp;
        StDnCmp: begin
          if (r_win) begin
            pos_q <= rc[IdxWidth-1:0]; state_q <= StDnRd;
          end else if (l_win) begin
            pos_q <= lc[IdxWidth-1:0]; state_q <= StDnRd;
          end else begin
            busy_q <= 1'b0; state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = busy_q; assign done_o = done_q; assign rsp_o = rsp_q;

endmodule

/* hw/rtl/heap_priority_queue_fifo_ties.sv */
// Top level: binary max-heap priority queue with oldest-first tie breaking.
// Errors are answered in the cycle after the request. An insert runs StUpRd and
// StUpCmp per level climbed; an extract runs StExRd and StExRoot, then StDnRd and
// StDnCmp per level descended unless it took the last entry (slot RAM reads are registered).
// One request at a time; busy stays high until the result strobe, and errors never raise it.
// The receiver cannot stall; done_o marks the result for one cycle.
// Reset empties the queue, clears the sequence counter and auto_discard.
module heap_priority_queue_fifo_ties
  import hpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic auto_discard_q;
  logic we;
  logic [IdxWidth-1:0] waddr, ra, rb;
  entry_t wdata, rda, rdb;
  logic start_req;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, auto_discard_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) auto_discard_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == 2'd0) auto_discard_q <= pwdata[0];
  end

  assign start_req = start && !busy;

  hpq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start_req), .req_i, .auto_discard_i(auto_discard_q),
    .busy_o(busy), .done_o, .rsp_o, .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .raddr_a_o(ra), .raddr_b_o(rb), .rdata_a_i(rda), .rdata_b_i(rdb)
  );

  hpq_ram #(.Width(EntWidth), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );

  // Result count never exceeds capacity.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.count <= CntWidth'(Capacity)) else $error("count overflow");
  // Errors return zero data_out.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != StatDone |-> rsp_o.data_out == '0)
    else $error("payload on error");
  // A request taken while idle is answered or makes the block busy.
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_req |=> busy || done_o) else $error("request lost");

endmodule

/* tb/sv/hpq_checker.sv */
// Checker: predicts the priority queue results and compares them with the block's output.
`timescale 1ns / 100ps
module hpq_checker
  import hpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  req_t       req_i,
  input  logic       done_o,
  input  rsp_t       rsp_o,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic       pready,
  output int         fail_count,
  output int         pending_count
);

  entry_t              heap_q [Capacity];
  int unsigned         fill;
  logic [SeqWidth-1:0] seq_next;
  logic                discard_on_full;
  rsp_t                expected_rsp_q [$];

  assign pending_count = expected_rsp_q.size();

  function automatic logic ahead_of(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.seq < b.seq;
  endfunction

  // work out the result of one request and update the shadow heap
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    int unsigned pos, up, best, l, rt;
    entry_t      tmp;
    o = '0;
    if (r.kind == KindInsert) begin
      if (fill >= Capacity && discard_on_full) fill = Capacity - 1;
      if (fill >= Capacity) begin
        o.status = StatFull;
      end else begin
        pos = fill;
        heap_q[pos] = '{data: r.data_in, prio: r.priority_in, seq: seq_next};
        seq_next++;
        fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!ahead_of(heap_q[pos], heap_q[up])) break;
          tmp = heap_q[pos]; heap_q[pos] = heap_q[up]; heap_q[up] = tmp;
          pos = up;
        end
      end
    end else if (fill == 0) begin
      o.status = StatEmpty;
    end else begin
      o.data_out     = heap_q[0].data;
      o.priority_out = heap_q[0].prio;
      fill--;
      if (fill > 0) begin
        heap_q[0] = heap_q[fill];
        pos = 0;
        forever begin
          best = pos;
          l = 2 * pos + 1;
          rt = 2 * pos + 2;
          if (l < fill && ahead_of(heap_q[l], heap_q[best])) best = l;
          if (rt < fill && ahead_of(heap_q[rt], heap_q[best])) best = rt;
          if (best == pos) break;
          tmp = heap_q[pos]; heap_q[pos] = heap_q[best]; heap_q[best] = tmp;
          pos = best;
        end
      end
    end
    o.count = fill[CntWidth-1:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      fill = 0;
      seq_next = '0;
      discard_on_full = 1'b0;
      fail_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'd0)
        discard_on_full = pwdata[0];
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with nothing pending: %p", $time, rsp_o);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, rsp_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(apply_request(req_i));
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: drives requests and register writes into the priority queue.
`timescale 1ns / 100ps
module tb_top;
  import hpq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  int          fail_count, pending_count;
  longint      cycle_count = 0;

  always #5 clk_i = ~clk_i;

  heap_priority_queue_fifo_ties i_dut (.*);
  hpq_checker i_chk (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("[heap_priority_queue_fifo_ties] ERROR");
      $finish;
    end
  end

  task automatic write_discard(logic v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {31'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // issue one request and hold start until it is taken
  task automatic send(logic k, logic [31:0] d, logic [7:0] p, bit gaps);
    int g;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        start <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    start <= 1'b1;
    req_i <= '{kind: k, data_in: d, priority_in: p};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic random_phase(int n, int ins_pct);
    logic [7:0] p;
    for (int i = 0; i < n; i++) begin
      // narrow priorities often, to force ties
      p = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      send(($urandom_range(0, 99) < ins_pct) ? KindInsert : KindExtract, $urandom, p, 1'b1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty extract, extremes, ties
    send(KindExtract, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send(KindInsert, 32'h0, 8'h00, 1'b0);
    send(KindInsert, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send(KindInsert, 32'h1111_1111, 8'h80, 1'b0);
    send(KindInsert, 32'h2222_2222, 8'h80, 1'b0);
    send(KindInsert, 32'h3333_3333, 8'h80, 1'b0);
    for (int i = 0; i < 6; i++) send(KindExtract, 32'h0, 8'h0, 1'b0);
    // fill and overflow with rejection
    for (int i = 0; i < Capacity + 3; i++) send(KindInsert, $urandom, 8'($urandom_range(0, 7)), 1'b0);
    drain();
    write_discard(1'b1);
    for (int i = 0; i < 5; i++) send(KindInsert, $urandom, 8'($urandom), 1'b0);
    random_phase(200, 50);
    drain();
    write_discard(1'b0);
    random_phase(300, 60);
    drain();
    write_discard(1'b1);
    random_phase(300, 65);
    random_phase(300, 35);
    drain();
    write_discard(1'b0);
    random_phase(250, 50);
    drain();
    if (fail_count == 0) begin
      $display("[heap_priority_queue_fifo_ties] OK");
    end else begin
      $display("[heap_priority_queue_fifo_ties] ERROR");
    end
    $finish;
  end

endmodule
